/* hw/rtl/plms_pkg.sv */
package plms_pkg;

	// Field widths
	localparam int TIME_W = 40;
	localparam int MASS_W = 32;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;

	// Default breakpoint table depth
	localparam int DEPTH_DEFAULT = 64;

	// Product of a mass difference and a time offset
	localparam int PROD_W  = TIME_W + MASS_W;
	// Time offset is multiplied in two halves of this width
	localparam int SPLIT_W = TIME_W / 2;

	// Divider step counter
	localparam int            DIV_CNT_W = $clog2(PROD_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

	// Item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV,
		ST_APPLY,
		ST_RESULT
	} state_t;

endpackage

/* hw/rtl/piecewise_linear_mass_schedule_top.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------------
// in       | input     | in_valid/in_stall  | kind, entry_index, entry_time, entry_mass,
//          |           |                    | query_time
// out      | output    | out_valid/out_stall| mass_value, mass_updated
// cfg      | input     | cfg_write_en       | cfg_write_data (entry_count)
//
// A load writes the breakpoint memory at its transfer.
// A query goes straight to its result when the table is empty, the time is early or at/after
// the last breakpoint; otherwise it searches with one memory read per cycle, multiplies the
// low and then the high half of the time offset, and then runs a restoring divider.
// Reset is asynchronous and clears the held mass and entry count; the memory needs no clearing.
// in_stall is high while a query is at work; a stalled result holds the next query's end.
module piecewise_linear_mass_schedule_top #(
	parameter int TABLE_DEPTH = plms_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [plms_pkg::IDX_W-1:0]   entry_index,
	input  logic [plms_pkg::TIME_W-1:0]  entry_time,
	input  logic [plms_pkg::MASS_W-1:0]  entry_mass,
	input  logic [plms_pkg::TIME_W-1:0]  query_time,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [plms_pkg::MASS_W-1:0]  mass_value,
	output logic                         mass_updated,
	input  logic                         cfg_write_en,
	input  logic [plms_pkg::CNT_W-1:0]   cfg_write_data
);

	import plms_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MEM_W = TIME_W + MASS_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   entry_count_q;
	logic [MASS_W-1:0]  held_q;
	logic               upd_q;
	logic               out_valid_q;
	logic [MASS_W-1:0]  mass_value_q;
	logic               mass_updated_q;

	logic [MEM_W-1:0]   bp_mem [TABLE_DEPTH];
	logic [MEM_W-1:0]   rd_q;
	logic [AW-1:0]      rd_addr;
	logic [TIME_W-1:0]  rd_time;
	logic [MASS_W-1:0]  rd_mass;
	logic               load_en;

	logic [CW-1:0]      n_cur;
	logic [AW-1:0]      last_q;
	logic [AW-1:0]      iss_q;
	logic [TIME_W-1:0]  query_q;
	logic [TIME_W-1:0]  t0_q;
	logic [MASS_W-1:0]  m0_q;
	logic [MASS_W-1:0]  dm_q;
	logic               neg_q;
	logic [TIME_W-1:0]  dq_q;
	logic [TIME_W-1:0]  dd_q;

	logic [PROD_W-1:0]  prod_q;
	logic [TIME_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [SPLIT_W-1:0] mul_b;
	logic [MASS_W+SPLIT_W-1:0] mul_p;
	logic [TIME_W:0]    rem_sh;
	logic               rem_ge;
	logic [TIME_W-1:0]  rem_nx;
	logic [MASS_W-1:0]  quo;

	assign rd_time = rd_q[MEM_W-1:MASS_W];
	assign rd_mass = rd_q[MASS_W-1:0];

	// Saturate the entry count at the table depth
	assign n_cur = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                       : CW'(entry_count_q);

	assign load_en = (state_q == ST_IDLE) && in_valid && (kind == KIND_LOAD)
	                 && (32'(entry_index) < 32'(TABLE_DEPTH));

	// Breakpoint memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_en) begin
			bp_mem[AW'(entry_index)] <= {entry_time, entry_mass};
		end
		rd_q <= bp_mem[rd_addr];
	end

	// Shared multiplier on one half of the time offset
	assign mul_b = (state_q == ST_MUL_LO) ? dq_q[SPLIT_W-1:0] : dq_q[TIME_W-1:SPLIT_W];
	assign mul_p = dm_q * mul_b;

	// One restoring divider step
	assign rem_sh = {rem_q, prod_q[PROD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dd_q};
	assign rem_nx = rem_ge ? TIME_W'(rem_sh - {1'b0, dd_q}) : rem_sh[TIME_W-1:0];
	assign quo    = prod_q[MASS_W-1:0];

	// Next state, read address and input stall
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_addr  = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && kind == KIND_QUERY) begin
					state_d = (n_cur == '0) ? ST_RESULT : ST_FIRST;
				end
			end
			ST_FIRST: begin
				rd_addr = last_q;
				state_d = (query_q < rd_time) ? ST_RESULT : ST_LAST;
			end
			ST_LAST: begin
				rd_addr = AW'(1);
				state_d = (query_q >= rd_time) ? ST_RESULT : ST_SCAN;
			end
			ST_SCAN: begin
				rd_addr = (iss_q == last_q) ? iss_q : iss_q + AW'(1);
				if (rd_time > query_q) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control: count register, held mass, indexes, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			held_q        <= '0;
			upd_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			last_q        <= '0;
			iss_q         <= '0;
			div_cnt_q     <= '0;
		end else begin
			if (cfg_write_en) begin
				entry_count_q <= cfg_write_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && kind == KIND_QUERY) begin
						last_q <= AW'(n_cur - CW'(1));
						upd_q  <= 1'b0;
					end
				end
				ST_FIRST: upd_q <= 1'b0;
				ST_LAST: begin
					iss_q <= AW'(1);
					if (query_q >= rd_time) begin
						held_q <= rd_mass;
						upd_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (rd_time <= query_q) begin
						iss_q <= iss_q + AW'(1);
					end
				end
				ST_MUL_HI: div_cnt_q <= '0;
				ST_DIV:    div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				ST_APPLY: begin
					held_q <= neg_q ? m0_q - quo : m0_q + quo;
					upd_q  <= 1'b1;
				end
				default: begin
				end
			endcase
			// Hold the result until transfer; load it when the slot frees
			if (state_q == ST_RESULT && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: lower breakpoint, operands, product and divider
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: query_q <= query_time;
			ST_FIRST: begin
				t0_q <= rd_time;
				m0_q <= rd_mass;
			end
			ST_SCAN: begin
				if (rd_time > query_q) begin
					dd_q  <= rd_time - t0_q;
					dq_q  <= query_q - t0_q;
					neg_q <= rd_mass < m0_q;
					dm_q  <= (rd_mass < m0_q) ? m0_q - rd_mass : rd_mass - m0_q;
				end else begin
					t0_q <= rd_time;
					m0_q <= rd_mass;
				end
			end
			ST_MUL_LO: prod_q <= PROD_W'(mul_p);
			ST_MUL_HI: begin
				prod_q <= prod_q + (PROD_W'(mul_p) << SPLIT_W);
				rem_q  <= '0;
			end
			ST_DIV: begin
				prod_q <= {prod_q[PROD_W-2:0], rem_ge};
				rem_q  <= rem_nx;
			end
			default: begin
			end
		endcase
		if (state_q == ST_RESULT && state_d == ST_IDLE) begin
			mass_value_q   <= held_q;
			mass_updated_q <= upd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mass_value   = mass_value_q;
	assign mass_updated = mass_updated_q;

`ifndef SYNTHESIS
	// Divisor is nonzero once interpolation starts
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL_LO |-> dd_q != '0)
		else $error("zero interpolation divisor");

	// Partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < dd_q)
		else $error("divider remainder out of range");

	// Quotient never exceeds the mass difference
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_cnt_q == DIV_LAST |=> prod_q <= PROD_W'(dm_q))
		else $error("interpolation quotient too large");

	// Search never reads past the last breakpoint in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> iss_q <= last_q)
		else $error("breakpoint search ran past the table end");
`endif

endmodule

/* test/plms_mass_checker.sv */
module plms_mass_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         kind,
	input  logic [plms_pkg::IDX_W-1:0]   entry_index,
	input  logic [plms_pkg::TIME_W-1:0]  entry_time,
	input  logic [plms_pkg::MASS_W-1:0]  entry_mass,
	input  logic [plms_pkg::TIME_W-1:0]  query_time,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [plms_pkg::MASS_W-1:0]  mass_value,
	input  logic                         mass_updated,
	input  logic                         cfg_write_en,
	input  logic [plms_pkg::CNT_W-1:0]   cfg_write_data,
	output int                           errors,
	output int                           outstanding
);

	localparam int DEPTH = plms_pkg::DEPTH_DEFAULT;

	typedef struct packed {
		logic [plms_pkg::MASS_W-1:0] mass;
		logic                        updated;
	} mass_report_t;

	// Shadow of the breakpoint table and the held mass
	logic [plms_pkg::TIME_W-1:0] bp_time [DEPTH];
	logic [plms_pkg::MASS_W-1:0] bp_mass [DEPTH];
	logic [plms_pkg::MASS_W-1:0] mass_now;
	logic [plms_pkg::CNT_W-1:0]  bp_len;
	mass_report_t                mass_due [$];
	int                          bad_fields = 0;

	// Evaluate the schedule at time q and update the held mass
	task interpolate_mass(input logic [plms_pkg::TIME_W-1:0] q, output logic updated);
		int                          n;
		int                          pos;
		logic [plms_pkg::TIME_W-1:0] t0;
		logic [plms_pkg::TIME_W-1:0] t1;
		logic [plms_pkg::MASS_W-1:0] m0;
		logic [plms_pkg::MASS_W-1:0] m1;
		logic [plms_pkg::PROD_W-1:0] corr;
		n = (bp_len > DEPTH) ? DEPTH : int'(bp_len);
		updated = 1'b1;
		if (n == 0 || q < bp_time[0]) begin
			updated = 1'b0;
		end else if (q >= bp_time[n-1]) begin
			mass_now = bp_mass[n-1];
		end else begin
			// stop at the first segment whose upper end lies after q
			pos = 0;
			while (pos + 1 < n && bp_time[pos+1] <= q)
				pos++;
			t0 = bp_time[pos];
			t1 = bp_time[pos+1];
			m0 = bp_mass[pos];
			m1 = bp_mass[pos+1];
			if (m1 >= m0) begin
				corr = (72'(m1 - m0) * 72'(q - t0)) / 72'(t1 - t0);
				mass_now = m0 + corr[plms_pkg::MASS_W-1:0];
			end else begin
				corr = (72'(m0 - m1) * 72'(q - t0)) / 72'(t1 - t0);
				mass_now = m0 - corr[plms_pkg::MASS_W-1:0];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		mass_report_t due;
		logic         upd;
		if (!arst_n) begin
			mass_due.delete();
			mass_now = '0;
			bp_len = '0;
			outstanding <= 0;
			errors <= bad_fields;
		end else begin
			// take register writes
			if (cfg_write_en)
				bp_len = cfg_write_data;
			// predict each accepted input transfer
			if (in_valid && !in_stall) begin
				if (kind == plms_pkg::KIND_LOAD) begin
					bp_time[entry_index] = entry_time;
					bp_mass[entry_index] = entry_mass;
				end else begin
					interpolate_mass(query_time, upd);
					mass_due.push_back('{mass: mass_now, updated: upd});
				end
			end
			// compare each result transfer with the oldest expectation
			if (out_valid && !out_stall) begin
				if (mass_due.size() == 0) begin
					$error("unexpected result: mass_value %0h, mass_updated %0b",
						mass_value, mass_updated);
					bad_fields++;
				end else begin
					due = mass_due.pop_front();
					if (mass_value !== due.mass) begin
						$error("mass_value: expected %0h, actual %0h", due.mass, mass_value);
						bad_fields++;
					end
					if (mass_updated !== due.updated) begin
						$error("mass_updated: expected %0b, actual %0b",
							due.updated, mass_updated);
						bad_fields++;
					end
				end
			end
			outstanding <= mass_due.size();
			errors <= bad_fields;
		end
	end

endmodule

/* test/tb_piecewise_linear_mass_schedule_top.sv */
module tb_piecewise_linear_mass_schedule_top;

	import plms_pkg::*;

	localparam int                 RANDOM_ITEMS = 950;
	localparam int                 HOLD_CYCLES  = 400;
	localparam int                 QUIET_LIMIT  = 4000;
	localparam int                 TABLE_SLOTS  = DEPTH_DEFAULT;
	localparam logic [TIME_W-1:0]  TIME_MAX     = '1;
	localparam logic [MASS_W-1:0]  MASS_MAX     = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid;
	logic                in_stall;
	logic                kind;
	logic [IDX_W-1:0]    entry_index;
	logic [TIME_W-1:0]   entry_time;
	logic [MASS_W-1:0]   entry_mass;
	logic [TIME_W-1:0]   query_time;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [MASS_W-1:0]   mass_value;
	logic                mass_updated;
	logic                cfg_write_en;
	logic [CNT_W-1:0]    cfg_write_data;

	int                  errors;
	int                  outstanding;
	int                  items_done = 0;
	int                  quiet_cycles = 0;
	int                  n_used = 0;
	logic [TIME_W-1:0]   shadow_time [TABLE_SLOTS];

	// receiver controls
	logic                calm = 1'b0;
	int                  holdoff_asks = 0;
	int                  holdoff_seen = 0;
	int                  hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	piecewise_linear_mass_schedule_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.entry_index    (entry_index),
		.entry_time     (entry_time),
		.entry_mass     (entry_mass),
		.query_time     (query_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mass_value     (mass_value),
		.mass_updated   (mass_updated),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	plms_mass_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.entry_index    (entry_index),
		.entry_time     (entry_time),
		.entry_mass     (entry_mass),
		.query_time     (query_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mass_value     (mass_value),
		.mass_updated   (mass_updated),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.errors         (errors),
		.outstanding    (outstanding)
	);

	// Receiver: random stalls, a long counted hold-off on request, none while calm
	always @(posedge clk) begin
		if (holdoff_seen != holdoff_asks) begin
			holdoff_seen <= holdoff_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 36);
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("piecewise_linear_mass_schedule_top: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [MASS_W-1:0] rand_mass();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return MASS_MAX;
		return $urandom();
	endfunction

	// Offer one item, idling first at random, and hold it until it transfers
	task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] t, input logic [MASS_W-1:0] m,
			input logic [TIME_W-1:0] qt);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		entry_index <= idx;
		entry_time <= t;
		entry_mass <= m;
		query_time <= qt;
		do
			@(posedge clk);
		while (in_stall);
		items_done++;
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] t,
			input logic [MASS_W-1:0] m);
		shadow_time[idx] = t;
		send_item(KIND_LOAD, idx, t, m, rand_time());
	endtask

	task automatic ask_mass(input logic [TIME_W-1:0] qt);
		send_item(KIND_QUERY, IDX_W'($urandom()), rand_time(), $urandom(), qt);
	endtask

	// Drop valid and wait until every result is back and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_count(input logic [CNT_W-1:0] v);
		drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		n_used = (v > TABLE_SLOTS) ? TABLE_SLOTS : int'(v);
	endtask

	// Write entries 0..n-1, with nondecreasing times or scrambled ones
	task automatic fill_breakpoints(input int n, input logic ordered);
		logic [63:0] acc;
		int          r;
		r = $urandom_range(99);
		if (r < 30)
			acc = 0;
		else if (r < 60)
			acc = $urandom_range(1, 5000);
		else
			acc = 64'(rand_time() >> 1);
		for (int i = 0; i < n; i++) begin
			if (!ordered) begin
				acc = 64'(rand_time());
			end else if (i != 0) begin
				r = $urandom_range(99);
				if (r < 15)
					acc = acc;
				else if (r < 55)
					acc = acc + $urandom_range(1, 1000);
				else if (r < 85)
					acc = acc + $urandom();
				else
					acc = acc + 64'(rand_time() >> $urandom_range(0, 8));
				if (acc > 64'(TIME_MAX))
					acc = 64'(TIME_MAX);
			end
			load_entry(IDX_W'(i), TIME_W'(acc), rand_mass());
		end
	endtask

	// Aim query times at the interesting spots of the current table
	function automatic logic [TIME_W-1:0] pick_query_time();
		int          r;
		int          i;
		logic [63:0] lo;
		logic [63:0] hi;
		r = $urandom_range(99);
		if (n_used == 0 || r < 10)
			return rand_time();
		if (r < 20) begin
			lo = 64'(shadow_time[0]);
			return (lo == 0) ? '0 : TIME_W'(64'({$urandom(), $urandom()}) % lo);
		end
		if (r < 35)
			return shadow_time[$urandom_range(0, n_used - 1)];
		if (r < 45 || n_used < 2) begin
			lo = 64'(shadow_time[n_used-1]) + $urandom_range(0, 3);
			return (lo > 64'(TIME_MAX)) ? TIME_MAX : TIME_W'(lo);
		end
		i = $urandom_range(0, n_used - 2);
		lo = 64'(shadow_time[i]);
		hi = 64'(shadow_time[i+1]);
		if (hi <= lo)
			return TIME_W'(lo);
		return TIME_W'(lo + 64'({$urandom(), $urandom()}) % (hi - lo));
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return $urandom_range(2, 8);
		else if (r < 85)
			return $urandom_range(9, 24);
		else if (r < 92)
			return $urandom_range(0, 1);
		return $urandom_range(64, 127);
	endfunction

	// Overwrite one entry: either the same time with a new mass, or anything
	task automatic random_load();
		logic [IDX_W-1:0] idx;
		if (n_used > 0 && $urandom_range(1))
			idx = IDX_W'($urandom_range(0, n_used - 1));
		else
			idx = IDX_W'($urandom());
		if ($urandom_range(1))
			load_entry(idx, shadow_time[idx], rand_mass());
		else
			load_entry(idx, rand_time(), rand_mass());
	endtask

	initial begin
		int   phase;
		int   n_req;
		int   mix;
		logic ordered;
		in_valid <= 1'b0;
		kind <= KIND_LOAD;
		entry_index <= '0;
		entry_time <= '0;
		entry_mass <= '0;
		query_time <= '0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		for (int i = 0; i < TABLE_SLOTS; i++)
			shadow_time[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: mass held at its reset value
		ask_mass('0);
		ask_mass(TIME_MAX);
		// widest segment: full mass swing over the full time range
		load_entry(0, '0, '0);
		load_entry(1, TIME_MAX, MASS_MAX);
		load_entry(63, TIME_MAX, MASS_MAX);
		set_count(2);
		ask_mass(TIME_MAX - 1);
		ask_mass(TIME_MAX);
		ask_mass('0);
		ask_mass(TIME_MAX >> 1);
		// falling mass, and a time before the first breakpoint
		load_entry(0, 10, MASS_MAX);
		load_entry(1, 20, '0);
		ask_mass(15);
		ask_mass(9);
		// repeated time at the end of the table
		load_entry(2, 20, 7);
		set_count(3);
		ask_mass(20);
		ask_mass(19);
		// out-of-order middle entry: search passes it
		load_entry(1, 5, 100);
		ask_mass(12);
		ask_mass(10);

		// random phases, each with its own entry count and table
		items_done = 0;
		phase = 0;
		while (items_done < RANDOM_ITEMS) begin
			case (phase)
				0: n_req = 64;
				1: n_req = 127;
				2: n_req = 1;
				3: n_req = 0;
				4: n_req = 65;
				default: n_req = pick_count();
			endcase
			ordered = ($urandom_range(99) < 80);
			set_count(CNT_W'(n_req));
			fill_breakpoints(n_used, ordered);
			// long receiver hold-off so the block backs up into its input
			if (phase == 1)
				holdoff_asks <= holdoff_asks + 1;
			calm <= (phase == 5);
			mix = (phase == 5) ? 60 : $urandom_range(20, 40);
			for (int k = 0; k < mix; k++) begin
				if ($urandom_range(99) < 25)
					random_load();
				else
					ask_mass(pick_query_time());
			end
			phase++;
		end
		calm <= 1'b0;

		drain();
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("piecewise_linear_mass_schedule_top: match");
		else
			$display("piecewise_linear_mass_schedule_top: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/plms_pkg.sv
hw/rtl/piecewise_linear_mass_schedule_top.sv
test/plms_mass_checker.sv
test/tb_piecewise_linear_mass_schedule_top.sv
